// ----- rtl/utf8_validate_count_unit_defines.svh -----
// utf8_validate_count_unit_defines.svh: assertion macros shared by the rtl
// expects clk and rst in scope at the place of use
`ifndef UTF8_VALIDATE_COUNT_UNIT_DEFINES_SVH
`define UTF8_VALIDATE_COUNT_UNIT_DEFINES_SVH

// plain property, checked outside reset
`define U8VC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// next-cycle implication, checked outside reset
`define U8VC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/utf8vc_pkg.sv -----
// utf8vc_pkg: types, constants and codes of the utf-8 checker and counter
// no dependencies
package utf8vc_pkg;

  // configuration
  localparam int CFG_W            = 10;
  localparam int CFG_INDEX_W      = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_CP = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_CP = 1'd1;
  localparam logic [CFG_W-1:0] MIN_CP_RESET = 10'd1;
  localparam logic [CFG_W-1:0] MAX_CP_RESET = 10'd128;

  // defaults for top level parameters
  localparam int COUNT_BITS_DEF   = 10;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // result word
  localparam int OUT_COUNT_W      = 10;
  localparam int OUT_TDATA_W      = 16;
  localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = 10'd1023;

  // code point limits
  localparam int CP_W = 21;
  localparam logic [CP_W-1:0] CP_MAX_1B   = 21'h00007F;
  localparam logic [CP_W-1:0] CP_MIN_3B   = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_4B   = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;

  // sequence lengths
  localparam logic [2:0] SEQ_LEN_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN_1    = 3'd1;
  localparam logic [2:0] SEQ_LEN_2    = 3'd2;
  localparam logic [2:0] SEQ_LEN_3    = 3'd3;
  localparam logic [2:0] SEQ_LEN_4    = 3'd4;

  // byte class decided by the front end
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ASCII,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_CONT,
    KIND_BAD
  } kind_t;

  // classified word held in the queue
  typedef struct packed {
    kind_t      kind;
    logic [6:0] payload;
    logic       is_end;
  } item_t;

endpackage

// ----- rtl/utf8vc_front.sv -----
// utf8vc_front: classifies one incoming byte into a queue item
// depends on utf8vc_pkg
module utf8vc_front (
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic             empty_string,
  output utf8vc_pkg::item_t item
);
  import utf8vc_pkg::*;

  // lead and continuation byte decode, payload bits masked per class
  always_comb begin
    item.is_end  = last_byte | empty_string;
    item.payload = 7'd0;
    item.kind    = KIND_BAD;
    if (empty_string) begin
      item.kind = KIND_NONE;
    end else begin
      case (data_byte) inside
        8'b0???????: begin
          item.kind    = KIND_ASCII;
          item.payload = data_byte[6:0];
        end
        8'b10??????: begin
          item.kind    = KIND_CONT;
          item.payload = {1'b0, data_byte[5:0]};
        end
        8'b110?????: begin
          item.kind    = KIND_LEAD2;
          item.payload = {2'b0, data_byte[4:0]};
        end
        8'b1110????: begin
          item.kind    = KIND_LEAD3;
          item.payload = {3'b0, data_byte[3:0]};
        end
        8'b11110???: begin
          item.kind    = KIND_LEAD4;
          item.payload = {4'b0, data_byte[2:0]};
        end
        default: begin
          item.kind = KIND_BAD;
        end
      endcase
    end
  end

endmodule

// ----- rtl/utf8vc_queue.sv -----
// utf8vc_queue: short fifo of classified items between front and back end
// depends on utf8vc_pkg and the assertion macro header
`include "utf8_validate_count_unit_defines.svh"

module utf8vc_queue #(
  parameter int DEPTH = utf8vc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  utf8vc_pkg::item_t wr_item,
  output logic              ready,
  input  logic              pop,
  output utf8vc_pkg::item_t rd_item,
  output logic              not_empty
);
  import utf8vc_pkg::*;

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign ready     = (fill != FILL_W'(DEPTH)) && !rst;
  assign not_empty = (fill != '0);
  assign rd_item   = slots[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  // checks
  `U8VC_ASSERT(a_no_pop_empty, pop |-> (fill != '0), "pop from empty queue")
  `U8VC_ASSERT_NEXT(a_fill_up, push && !pop, fill == $past(fill) + FILL_W'(1), "fill did not rise")
  `U8VC_ASSERT_NEXT(a_fill_dn, pop && !push, fill == $past(fill) - FILL_W'(1), "fill did not fall")

endmodule

// ----- rtl/utf8vc_back.sv -----
// utf8vc_back: decodes queued items, counts code points, holds the result word
// depends on utf8vc_pkg and the assertion macro header
`include "utf8_validate_count_unit_defines.svh"

module utf8vc_back #(
  parameter int COUNT_BITS = utf8vc_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [utf8vc_pkg::CFG_W-1:0]       min_cp,
  input  logic [utf8vc_pkg::CFG_W-1:0]       max_cp,
  input  logic                               q_not_empty,
  input  utf8vc_pkg::item_t                  q_item,
  output logic                               pop,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [utf8vc_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import utf8vc_pkg::*;

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam logic [COUNT_BITS-1:0] CNT_ALL = {COUNT_BITS{1'b1}};

  // string state
  logic [1:0]            pend;
  logic [2:0]            seq_len;
  logic [CP_W-1:0]       part;
  logic [COUNT_BITS-1:0] cnt;
  logic                  err;

  logic [1:0]            pend_next;
  logic [2:0]            seq_len_next;
  logic [CP_W-1:0]       part_next;
  logic [COUNT_BITS-1:0] cnt_next;
  logic                  err_next;

  logic                  fin_en;
  logic [CP_W-1:0]       fin_cp;
  logic [2:0]            fin_len;
  logic [CP_W-1:0]       part_sh;
  logic                  fin_bad;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      cnt_next_ext;
  logic                  res_valid;
  logic [OUT_COUNT_W-1:0] res_count;
  logic                  out_free;

  // end items wait for a free output register, others flow straight through
  assign out_free = !m_tvalid || m_tready;
  assign pop      = q_not_empty && (!q_item.is_end || out_free);
  assign part_sh  = {part[CP_W-7:0], q_item.payload[5:0]};
  assign cnt_ext  = CMP_W'(cnt);

  // per-item state update
  always_comb begin
    pend_next    = pend;
    seq_len_next = seq_len;
    part_next    = part;
    cnt_next     = cnt;
    err_next     = err;
    fin_en       = 1'b0;
    fin_cp       = '0;
    fin_len      = SEQ_LEN_NONE;
    fin_bad      = 1'b0;
    cnt_next_ext = '0;
    res_valid    = 1'b0;
    res_count    = '0;
    if (pop) begin
      // byte decode against the open sequence
      if (q_item.kind != KIND_NONE && !err) begin
        if (pend == 2'd0) begin
          case (q_item.kind)
            KIND_ASCII: begin
              fin_en  = 1'b1;
              fin_cp  = CP_W'(q_item.payload);
              fin_len = SEQ_LEN_1;
            end
            KIND_LEAD2: begin
              seq_len_next = SEQ_LEN_2;
              pend_next    = 2'd1;
              part_next    = CP_W'(q_item.payload);
            end
            KIND_LEAD3: begin
              seq_len_next = SEQ_LEN_3;
              pend_next    = 2'd2;
              part_next    = CP_W'(q_item.payload);
            end
            KIND_LEAD4: begin
              seq_len_next = SEQ_LEN_4;
              pend_next    = 2'd3;
              part_next    = CP_W'(q_item.payload);
            end
            default: begin
              err_next = 1'b1;
            end
          endcase
        end else if (q_item.kind != KIND_CONT) begin
          err_next = 1'b1;
        end else begin
          pend_next = pend - 2'd1;
          if (pend == 2'd1) begin
            fin_en       = 1'b1;
            fin_cp       = part_sh;
            fin_len      = seq_len;
            seq_len_next = SEQ_LEN_NONE;
            part_next    = '0;
          end else begin
            part_next = part_sh;
          end
        end
      end

      // completed code point: range checks and counting
      if (fin_en) begin
        fin_bad = (fin_len == SEQ_LEN_2 && fin_cp <= CP_MAX_1B) ||
                  (fin_len == SEQ_LEN_3 && fin_cp < CP_MIN_3B) ||
                  (fin_len == SEQ_LEN_4 && fin_cp < CP_MIN_4B) ||
                  (fin_cp > CP_MAX) ||
                  (fin_cp >= CP_SURR_LO && fin_cp <= CP_SURR_HI) ||
                  (fin_cp == '0);
        if (fin_bad) begin
          err_next = 1'b1;
        end else begin
          if (cnt_ext >= CMP_W'(max_cp)) begin
            err_next = 1'b1;
          end
          if (cnt != CNT_ALL) begin
            cnt_next = cnt + COUNT_BITS'(1);
          end
        end
      end

      // string end: verdict, then clear for the next string
      if (q_item.is_end) begin
        cnt_next_ext = CMP_W'(cnt_next);
        res_valid    = !err_next && (pend_next == 2'd0) &&
                       (cnt_next_ext >= CMP_W'(min_cp)) &&
                       (cnt_next_ext <= CMP_W'(max_cp));
        res_count    = (cnt_next_ext > CMP_W'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                               : cnt_next_ext[OUT_COUNT_W-1:0];
        pend_next    = 2'd0;
        seq_len_next = SEQ_LEN_NONE;
        part_next    = '0;
        cnt_next     = '0;
        err_next     = 1'b0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= 2'd0;
      seq_len <= SEQ_LEN_NONE;
      part    <= '0;
      cnt     <= '0;
      err     <= 1'b0;
    end else begin
      pend    <= pend_next;
      seq_len <= seq_len_next;
      part    <= part_next;
      cnt     <= cnt_next;
      err     <= err_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && q_item.is_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.is_end) begin
      m_tdata <= {(OUT_TDATA_W - OUT_COUNT_W - 1)'(0), res_count, res_valid};
    end
  end

  // checks
  `U8VC_ASSERT(a_seq_pend, (pend == 2'd0) == (seq_len == SEQ_LEN_NONE), "sequence length out of step")
  `U8VC_ASSERT_NEXT(a_err_hold, pop && err && !q_item.is_end, (pend == $past(pend)) && (cnt == $past(cnt)), "state moved after error")
  `U8VC_ASSERT_NEXT(a_end_loads, pop && q_item.is_end, m_tvalid, "string end gave no result")

endmodule

// ----- rtl/utf8_validate_count_unit.sv -----
// utf8_validate_count_unit: strict utf-8 checker and code point counter
// result word: the last byte is held in the queue, then decoded and captured in the output register
// throughput: one byte per cycle while the queue has room; a queue of QUEUE_DEPTH words parts the two ends
// a held result word halts the back end at a string end; input stops once the queue is full
// rst is synchronous: string state cleared, queue emptied, limits back to 1 and 128
module utf8_validate_count_unit #(
  parameter int COUNT_BITS  = utf8vc_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = utf8vc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_wr_en,
  input  logic [utf8vc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [utf8vc_pkg::CFG_W-1:0]       cfg_wdata,
  // byte stream in
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // data_byte
  input  logic                               s_tlast,  // last_byte
  input  logic                               s_tuser,  // empty_string
  // result stream out
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [utf8vc_pkg::OUT_TDATA_W-1:0] m_tdata   // string_valid, codepoint_count
);
  import utf8vc_pkg::*;

  logic [CFG_W-1:0] min_cp;
  logic [CFG_W-1:0] max_cp;
  item_t            f_item;
  item_t            q_item;
  logic             q_not_empty;
  logic             pop;
  logic             push;

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_cp <= MIN_CP_RESET;
      max_cp <= MAX_CP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIN_CP: min_cp <= cfg_wdata;
        REG_MAX_CP: max_cp <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign push = s_tvalid && s_tready;

  // front end: byte classification
  utf8vc_front u_front (
    .data_byte    (s_tdata),
    .last_byte    (s_tlast),
    .empty_string (s_tuser),
    .item         (f_item)
  );

  // queue between the two ends
  utf8vc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_item   (f_item),
    .ready     (s_tready),
    .pop       (pop),
    .rd_item   (q_item),
    .not_empty (q_not_empty)
  );

  // back end: sequence tracking, counting and result word
  utf8vc_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .min_cp      (min_cp),
    .max_cp      (max_cp),
    .q_not_empty (q_not_empty),
    .q_item      (q_item),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

// ----- tb/utf8_validate_count_unit_checker.sv -----
// utf8_validate_count_unit_checker: watches the config port and both streams,
// predicts each string verdict and compares it with the result word
// depends on utf8vc_pkg for register indexes, widths and code point limits
`timescale 1ns / 1ps

module utf8_validate_count_unit_checker #(
  parameter int COUNT_BITS = utf8vc_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [utf8vc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [utf8vc_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [7:0]                         s_tdata,  // data_byte
  input  logic                               s_tlast,  // last_byte
  input  logic                               s_tuser,  // empty_string
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [utf8vc_pkg::OUT_TDATA_W-1:0] m_tdata,  // string_valid, codepoint_count
  output int                                 fault_count,
  output int                                 verdicts_waiting,
  output int                                 strings_checked
);
  import utf8vc_pkg::*;

  typedef struct packed {
    logic                   ok;
    logic [OUT_COUNT_W-1:0] count;
  } verdict_t;

  // own copy of the limits
  logic [CFG_W-1:0] min_cp;
  logic [CFG_W-1:0] max_cp;

  // own copy of the per-string scan state
  logic [1:0]            cont_left;
  logic [2:0]            seq_bytes;
  logic [CP_W-1:0]       cp_acc;
  logic [COUNT_BITS-1:0] cp_total;
  logic                  string_bad;

  verdict_t verdicts_due[$];

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void clear_scan();
    cont_left  = 2'd0;
    seq_bytes  = SEQ_LEN_NONE;
    cp_acc     = '0;
    cp_total   = '0;
    string_bad = 1'b0;
  endfunction

  // a finished code point: reject bad values, else count it against the maximum
  function automatic void close_codepoint(input logic [CP_W-1:0] cp, input logic [2:0] len);
    logic overlong;
    overlong = (len == SEQ_LEN_2 && cp <= CP_MAX_1B) ||
               (len == SEQ_LEN_3 && cp < CP_MIN_3B) ||
               (len == SEQ_LEN_4 && cp < CP_MIN_4B);
    if (overlong || cp > CP_MAX || (cp >= CP_SURR_LO && cp <= CP_SURR_HI) || cp == '0) begin
      string_bad = 1'b1;
    end else begin
      if (cp_total >= max_cp) string_bad = 1'b1;
      if (cp_total != {COUNT_BITS{1'b1}}) cp_total = cp_total + 1'b1;
    end
  endfunction

  // one byte of the string; nothing is looked at once the string has gone bad
  function automatic void scan_byte(input logic [7:0] b);
    if (!string_bad) begin
      if (cont_left == 2'd0) begin
        if (b <= CP_MAX_1B[7:0]) begin
          close_codepoint({13'd0, b}, SEQ_LEN_1);
        end else if (b[7:5] == 3'b110) begin
          seq_bytes = SEQ_LEN_2; cont_left = 2'd1; cp_acc = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          seq_bytes = SEQ_LEN_3; cont_left = 2'd2; cp_acc = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          seq_bytes = SEQ_LEN_4; cont_left = 2'd3; cp_acc = {18'd0, b[2:0]};
        end else begin
          string_bad = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        string_bad = 1'b1;
      end else begin
        cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          close_codepoint(cp_acc, seq_bytes);
          seq_bytes = SEQ_LEN_NONE;
          cp_acc    = '0;
        end
      end
    end
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    verdict_t    want;
    verdict_t    made;
    int unsigned total;
    if (rst) begin
      min_cp = MIN_CP_RESET;
      max_cp = MAX_CP_RESET;
      clear_scan();
      verdicts_due.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_MIN_CP) min_cp = cfg_wdata;
        else if (cfg_index == REG_MAX_CP) max_cp = cfg_wdata;
      end

      // result side: compare with the oldest verdict
      if (m_tvalid && m_tready) begin
        if (verdicts_due.size() == 0) begin
          note_fault($sformatf("result word %h with no string outstanding", m_tdata));
        end else begin
          want = verdicts_due.pop_front();
          strings_checked++;
          if (m_tdata[0] !== want.ok || m_tdata[OUT_COUNT_W:1] !== want.count)
            note_fault($sformatf("string %0d: expected valid=%0b count=%0d, got valid=%0b count=%0d",
                                 strings_checked, want.ok, want.count,
                                 m_tdata[0], m_tdata[OUT_COUNT_W:1]));
        end
      end

      // byte side: advance the scan, and on a string end queue its verdict
      if (s_tvalid && s_tready) begin
        if (!s_tuser) scan_byte(s_tdata);
        if (s_tuser || s_tlast) begin
          if (cont_left != 2'd0) string_bad = 1'b1;
          total      = cp_total;
          made.ok    = !string_bad && cp_total >= min_cp && cp_total <= max_cp;
          made.count = (total > OUT_COUNT_MAX) ? OUT_COUNT_MAX : total[OUT_COUNT_W-1:0];
          verdicts_due.push_back(made);
          clear_scan();
        end
      end
    end
    verdicts_waiting = verdicts_due.size();
  end

endmodule

// ----- tb/utf8_validate_count_unit_tb.sv -----
// utf8_validate_count_unit_tb: drives strings of bytes and limit settings into the
// checker/counter, with the checker alongside to predict and compare
// depends on utf8vc_pkg, utf8_validate_count_unit and utf8_validate_count_unit_checker
`timescale 1ns / 1ps

module utf8_validate_count_unit_tb;
  import utf8vc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_AT      = 100;
  localparam int STALL_CYCLES  = 300;
  localparam int SHIFT_A       = 650;
  localparam int SHIFT_B       = 1300;

  typedef enum logic [1:0] {END_LAST, END_EMPTY, END_BOTH} end_style_t;
  typedef enum logic [2:0] {
    FAULT_NOISE, FAULT_OVERLONG, FAULT_SURROGATE, FAULT_ABOVE,
    FAULT_NUL, FAULT_CUT, FAULT_BAD_CONT
  } fault_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;
  logic                   s_tlast;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int fault_count;
  int verdicts_waiting;
  int strings_checked;
  int words_sent  = 0;
  int cycle_count = 0;
  int limits_used = 0;
  int stall_left  = 0;
  bit stall_done  = 1'b0;

  // bytes of the string being built
  logic [7:0] text[$];

  always #1 clk = ~clk;

  utf8_validate_count_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  utf8_validate_count_unit_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fault_count(fault_count), .verdicts_waiting(verdicts_waiting),
    .strings_checked(strings_checked)
  );

  // run time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count, verdicts_waiting);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // idle rates move through three stretches of the run
  function automatic int sender_idle_pct();
    return (words_sent < SHIFT_A) ? 29 : (words_sent < SHIFT_B) ? 60 : 0;
  endfunction

  function automatic int receiver_idle_pct();
    return (words_sent < SHIFT_A) ? 60 : (words_sent < SHIFT_B) ? 29 : 0;
  endfunction

  // result side: random back-pressure plus one long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stall_done && words_sent >= STALL_AT) begin
        stall_left = STALL_CYCLES;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
    end
  end

  // utf-8 encoding of cp in len bytes; bits above the form are dropped
  function automatic void put_seq(input int unsigned cp, input int len);
    case (len)
      1: text.push_back({1'b0, cp[6:0]});
      2: begin
        text.push_back({3'b110, cp[10:6]});
        text.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text.push_back({4'b1110, cp[15:12]});
        text.push_back({2'b10, cp[11:6]});
        text.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text.push_back({5'b11110, cp[20:18]});
        text.push_back({2'b10, cp[17:12]});
        text.push_back({2'b10, cp[11:6]});
        text.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // a well-formed code point of random length
  function automatic void put_valid();
    int unsigned cp;
    case ($urandom_range(0, 3))
      0: put_seq($urandom_range(1, 'h7F), 1);
      1: put_seq($urandom_range('h80, 'h7FF), 2);
      2: begin
        cp = $urandom_range('h800, 'hF7FF);
        if (cp >= 'hD800) cp = cp + 'h800;
        put_seq(cp, 3);
      end
      default: put_seq($urandom_range('h10000, 'h10FFFF), 4);
    endcase
  endfunction

  // one broken element of some kind
  function automatic void put_fault();
    fault_t     kind;
    int         len;
    logic [7:0] b;
    kind = fault_t'($urandom_range(0, 6));
    case (kind)
      FAULT_NOISE:     text.push_back(8'($urandom_range(0, 255)));
      FAULT_OVERLONG: begin
        len = $urandom_range(2, 4);
        if (len == 2) put_seq($urandom_range(0, 'h7F), 2);
        else if (len == 3) put_seq($urandom_range(0, 'h7FF), 3);
        else put_seq($urandom_range(0, 'hFFFF), 4);
      end
      FAULT_SURROGATE: put_seq($urandom_range('hD800, 'hDFFF), 3);
      FAULT_ABOVE:     put_seq($urandom_range('h110000, 'h1FFFFF), 4);
      FAULT_NUL:       text.push_back(8'h00);
      FAULT_CUT: begin
        len = $urandom_range(2, 4);
        put_seq($urandom_range('h10000, 'h10FFFF), len);
        repeat ($urandom_range(1, len - 1)) void'(text.pop_back());
      end
      default: begin
        // lead byte followed by anything but a continuation byte
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        text.push_back(8'hE2);
        text.push_back(b);
      end
    endcase
  endfunction

  // random string: most are clean, some carry faults here and there
  task automatic compose_string(input int max_cps, output end_style_t style);
    int n;
    int roll;
    bit messy;
    text.delete();
    n     = $urandom_range(0, max_cps);
    messy = ($urandom_range(0, 99) < 30);
    for (int i = 0; i < n; i++) begin
      if (messy && $urandom_range(0, 99) < 20) put_fault();
      else put_valid();
    end
    roll  = $urandom_range(0, 99);
    style = (roll < 80) ? END_LAST : (roll < 90) ? END_EMPTY : END_BOTH;
  endtask

  // offer one word and hold it until taken; entered and left at a falling edge
  task automatic push_word(input logic [7:0] b, input logic l, input logic e);
    while ($urandom_range(0, 99) < sender_idle_pct()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    s_tuser  <= e;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // send the text, closing it with tlast or with an empty-string word
  task automatic send_text(input end_style_t style);
    for (int i = 0; i < text.size(); i++)
      push_word(text[i], style == END_LAST && i == text.size() - 1, 1'b0);
    if (text.size() == 0 || style != END_LAST)
      push_word(8'($urandom_range(0, 255)), style == END_BOTH, 1'b1);
  endtask

  // stop offering until every verdict is back, then let the queue drain
  task automatic settle();
    s_tvalid <= 1'b0;
    while (verdicts_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // new limits, then random strings until the word budget is spent
  task automatic run_phase(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                           input int budget, input int max_cps);
    int         stop;
    end_style_t style;
    settle();
    write_reg(REG_MIN_CP, lo);
    write_reg(REG_MAX_CP, hi);
    limits_used++;
    stop = words_sent + budget;
    while (words_sent < stop) begin
      compose_string(max_cps, style);
      send_text(style);
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    s_tuser   = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed strings under the reset limits
    limits_used++;
    text.delete();
    send_text(END_EMPTY);
    // top ascii, then nul, then a byte after the error
    text = '{8'h7F, 8'h00, 8'h41};
    send_text(END_LAST);
    // smallest 2 and 3 byte forms and the largest code point
    text = '{8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text(END_LAST);
    // surrogate
    text = '{8'hED, 8'hA0, 8'h80};
    send_text(END_LAST);
    // just above the code point range
    text = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_text(END_LAST);
    // overlong 2 byte form
    text = '{8'hC0, 8'h80};
    send_text(END_LAST);
    // bad lead byte
    text = '{8'hFF};
    send_text(END_LAST);
    // lead byte without its continuation
    text = '{8'hC3, 8'h41};
    send_text(END_LAST);
    // unfinished sequence closed by an empty-string word
    text = '{8'hE2, 8'h82};
    send_text(END_EMPTY);
    // tlast and tuser together on one word
    text = '{8'h41};
    send_text(END_BOTH);
    // unfinished sequence closed by tlast
    text = '{8'hF0};
    send_text(END_LAST);

    // random strings under a run of limit settings
    run_phase(10'd1, 10'd128, 200, 10);
    run_phase(10'd0, 10'd0, 200, 3);
    run_phase(10'd3, 10'd5, 250, 8);
    run_phase(10'd1023, 10'd1023, 60, 6);
    // one string long enough to pass the top of the count
    text.delete();
    repeat (1025) text.push_back(8'($urandom_range(1, 127)));
    send_text(END_LAST);
    run_phase(10'd0, 10'd1023, 150, 12);
    run_phase(10'd1023, 10'd0, 50, 3);

    settle();
    $display("checked %0d string verdicts from %0d input words under %0d limit settings",
             strings_checked, words_sent, limits_used);
    $display("run included a %0d-cycle result hold-off and a 1025 code point string",
             STALL_CYCLES);
    if (fault_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
